>>> rtl/ycbcr_to_bgra_pixel_converter_core_macros.svh
// assertion helpers for the bgra converter
`ifndef YCBCR_TO_BGRA_PIXEL_CONVERTER_CORE_MACROS_SVH
`define YCBCR_TO_BGRA_PIXEL_CONVERTER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define YBC_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error(msg);

// next-cycle implication, disabled while reset is held
`define YBC_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

>>> rtl/ybc_pkg.sv
package ybc_pkg;

	localparam int COEF_FRAC_BITS = 16;
	// unsigned Q2.F coefficients
	localparam int COEF_W = COEF_FRAC_BITS + 2;
	// signed coefficient times signed 8-bit chroma offset
	localparam int PROD_W = COEF_W + 1 + 8;
	// luma term plus up to two products, with headroom
	localparam int SUM_W = COEF_FRAC_BITS + 12;

	localparam longint unsigned K_SCALE = 100000;

	localparam logic [COEF_W-1:0] COEF_CR_R =
		COEF_W'(((64'd140200 << COEF_FRAC_BITS) + K_SCALE / 2) / K_SCALE);
	localparam logic [COEF_W-1:0] COEF_CB_G =
		COEF_W'(((64'd34414 << COEF_FRAC_BITS) + K_SCALE / 2) / K_SCALE);
	localparam logic [COEF_W-1:0] COEF_CR_G =
		COEF_W'(((64'd71414 << COEF_FRAC_BITS) + K_SCALE / 2) / K_SCALE);
	localparam logic [COEF_W-1:0] COEF_CB_B =
		COEF_W'(((64'd177200 << COEF_FRAC_BITS) + K_SCALE / 2) / K_SCALE);

	localparam logic [7:0] BYTE_MAX = 8'hFF;

	typedef enum logic [1:0] {
		PT_RGB   = 2'd0,
		PT_YCBCR = 2'd1,
		PT_RGBA  = 2'd2,
		PT_UNSUP = 2'd3
	} pixel_type_t;

	typedef struct packed {
		logic [7:0] sample_plane0;
		logic [7:0] sample_plane1;
		logic [7:0] sample_plane2;
		logic [7:0] alpha_sample;
		logic       alpha_present;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_byte0;
		logic [7:0] out_byte1;
		logic [7:0] out_byte2;
		logic [7:0] out_alpha;
		logic       type_error;
	} pix_out_t;

	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

>>> rtl/ycbcr_to_bgra_pixel_converter_core.sv
// pixel converter: three plane samples (plus optional alpha) in, one bgra word out
// input channel: in_valid / in_stall / in_data, one pixel request per accept
// output channel: out_valid / out_stall / out_data, exactly one result per request
// config: cfg_we writes cfg_wdata into pixel_type (rgb, ycbcr, rgba, unsupported);
//   write it only while the pipeline is empty
// latency: out_valid rises 3 cycles after the accepting edge, with no stalls
// throughput: one pixel per clock, set by the four-stage pipeline
//   (capture, multiply, sum, clamp/select); no loops, no shared units
// reset (arst_n low): all stage valids clear, pixel_type returns to ycbcr
// receiver stall: the output word holds; empty stages behind it still fill,
//   and in_stall rises only once the first stage holds a request it cannot pass on
// unsupported type: type_error set, all four bytes zero
`include "ycbcr_to_bgra_pixel_converter_core_macros.svh"

module ycbcr_to_bgra_pixel_converter_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  ybc_pkg::pix_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output ybc_pkg::pix_out_t out_data
);

	// configuration register
	ybc_pkg::pixel_type_t pixel_type_q;

	// stage valids and load enables
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic load_s1, load_s2, load_s3, load_s4;

	// stage 1: captured samples, alpha already resolved
	logic [7:0]           p0_s1, p1_s1, p2_s1, alpha_s1;
	ybc_pkg::pixel_type_t mode_s1;

	// stage 2: products
	ybc_pkg::prod_t       prod_r_s2, prod_gb_s2, prod_gr_s2, prod_b_s2;
	logic [7:0]           p0_s2, p1_s2, p2_s2, alpha_s2;
	ybc_pkg::pixel_type_t mode_s2;

	// stage 3: channel sums
	ybc_pkg::sum_t        sum_r_s3, sum_g_s3, sum_b_s3;
	logic [7:0]           p0_s3, p1_s3, p2_s3, alpha_s3;
	ybc_pkg::pixel_type_t mode_s3;

	// stage 4: output word
	ybc_pkg::pix_out_t    out_s4;
	ybc_pkg::pixel_type_t mode_s4;

	// combinational helpers
	logic                 alpha_in;
	logic signed [7:0]    cb, cr;
	ybc_pkg::sum_t        y_term;
	ybc_pkg::pix_out_t    out_next;

	// truncate a Q(F) sum toward zero, clamp to a byte
	function automatic logic [7:0] trunc_clamp(input ybc_pkg::sum_t s);
		logic [7:0] res;
		if (s[ybc_pkg::SUM_W-1]) begin
			res = 8'd0;
		end else if (|s[ybc_pkg::SUM_W-2:ybc_pkg::COEF_FRAC_BITS+8]) begin
			res = ybc_pkg::BYTE_MAX;
		end else begin
			res = s[ybc_pkg::COEF_FRAC_BITS+7:ybc_pkg::COEF_FRAC_BITS];
		end
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_type_q <= ybc_pkg::PT_YCBCR;
		end else if (cfg_we) begin
			pixel_type_q <= ybc_pkg::pixel_type_t'(cfg_wdata);
		end
	end

	// a stage takes new content when empty or when its content moves on
	assign load_s4 = !valid_s4 || !out_stall;
	assign load_s3 = !valid_s3 || load_s4;
	assign load_s2 = !valid_s2 || load_s3;
	assign load_s1 = !valid_s1 || load_s2;

	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (load_s3) begin
				valid_s3 <= valid_s2;
			end
			if (load_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// alpha only comes from the sample in rgba mode with the sample present
	assign alpha_in = (pixel_type_q == ybc_pkg::PT_RGBA) && in_data.alpha_present;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			p0_s1    <= in_data.sample_plane0;
			p1_s1    <= in_data.sample_plane1;
			p2_s1    <= in_data.sample_plane2;
			alpha_s1 <= alpha_in ? in_data.alpha_sample : ybc_pkg::BYTE_MAX;
			mode_s1  <= pixel_type_q;
		end
	end

	// sample minus 128 is the sample with its top bit flipped, read as signed
	assign cb = $signed({~p1_s1[7], p1_s1[6:0]});
	assign cr = $signed({~p2_s1[7], p2_s1[6:0]});

	always_ff @(posedge clk) begin
		if (load_s2) begin
			prod_r_s2  <= ybc_pkg::prod_t'($signed({1'b0, ybc_pkg::COEF_CR_R})) *
				ybc_pkg::prod_t'(cr);
			prod_gb_s2 <= ybc_pkg::prod_t'($signed({1'b0, ybc_pkg::COEF_CB_G})) *
				ybc_pkg::prod_t'(cb);
			prod_gr_s2 <= ybc_pkg::prod_t'($signed({1'b0, ybc_pkg::COEF_CR_G})) *
				ybc_pkg::prod_t'(cr);
			prod_b_s2  <= ybc_pkg::prod_t'($signed({1'b0, ybc_pkg::COEF_CB_B})) *
				ybc_pkg::prod_t'(cb);
			p0_s2      <= p0_s1;
			p1_s2      <= p1_s1;
			p2_s2      <= p2_s1;
			alpha_s2   <= alpha_s1;
			mode_s2    <= mode_s1;
		end
	end

	// luma in Q(F), zero extended
	assign y_term = $signed(ybc_pkg::SUM_W'({p0_s2, {ybc_pkg::COEF_FRAC_BITS{1'b0}}}));

	always_ff @(posedge clk) begin
		if (load_s3) begin
			sum_r_s3 <= y_term + ybc_pkg::SUM_W'(prod_r_s2);
			sum_g_s3 <= y_term - ybc_pkg::SUM_W'(prod_gb_s2) - ybc_pkg::SUM_W'(prod_gr_s2);
			sum_b_s3 <= y_term + ybc_pkg::SUM_W'(prod_b_s2);
			p0_s3    <= p0_s2;
			p1_s3    <= p1_s2;
			p2_s3    <= p2_s2;
			alpha_s3 <= alpha_s2;
			mode_s3  <= mode_s2;
		end
	end

	// final select per mode
	always_comb begin
		out_next = '0;
		case (mode_s3)
			ybc_pkg::PT_RGB, ybc_pkg::PT_RGBA: begin
				out_next.out_byte0 = p0_s3;
				out_next.out_byte1 = p1_s3;
				out_next.out_byte2 = p2_s3;
				out_next.out_alpha = alpha_s3;
			end
			ybc_pkg::PT_YCBCR: begin
				out_next.out_byte0 = trunc_clamp(sum_b_s3);
				out_next.out_byte1 = trunc_clamp(sum_g_s3);
				out_next.out_byte2 = trunc_clamp(sum_r_s3);
				out_next.out_alpha = ybc_pkg::BYTE_MAX;
			end
			default: begin
				out_next.type_error = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_s4) begin
			out_s4  <= out_next;
			mode_s4 <= mode_s3;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = out_s4;

	// checks on the pipeline's own logic
	`YBC_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && !in_stall, valid_s1,
		"accepted request did not land in stage 1")
	`YBC_ASSERT_IMPLY(a_stall_only_when_full, clk, arst_n, in_stall, valid_s1 && valid_s2,
		"input stalled with an empty stage ahead")
	`YBC_ASSERT_IMPLY(a_error_zero_bytes, clk, arst_n, out_valid && out_data.type_error,
		out_data.out_byte0 == 8'd0 && out_data.out_byte1 == 8'd0 &&
		out_data.out_byte2 == 8'd0 && out_data.out_alpha == 8'd0,
		"type error result carries nonzero bytes")
	`YBC_ASSERT_IMPLY(a_opaque_alpha, clk, arst_n,
		out_valid && (mode_s4 == ybc_pkg::PT_RGB || mode_s4 == ybc_pkg::PT_YCBCR),
		out_data.out_alpha == ybc_pkg::BYTE_MAX && !out_data.type_error,
		"alpha not opaque outside rgba mode")

endmodule
